// ===== hw/rtl/blrc_pkg.sv =====
// Shared types and constants for the backlight level ramp controller.
// Used by the serial multiplier, the serial divider and the core top level.
package blrc_pkg;

	localparam int BRIGHT_W     = 16;
	localparam int LEVEL_W      = 10;
	localparam int CMD_W        = 3;
	localparam int PROD_W       = 2 * BRIGHT_W;
	localparam int NUM_W        = PROD_W + 2;
	localparam int DEN_W        = BRIGHT_W + 1;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = BRIGHT_W;
	localparam int DIRECT_LIMIT = 20;

	// command codes
	localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INC    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DEC    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ON     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_OFF    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SWITCH = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BRIGHT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_BRIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_CNT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_TIME  = 3'd4;

	// register reset values
	localparam logic [BRIGHT_W-1:0] RST_MAX_BRIGHT = 16'd255;
	localparam logic [BRIGHT_W-1:0] RST_MIN_BRIGHT = 16'd0;
	localparam logic [LEVEL_W-1:0]  RST_LEVEL_CNT  = 10'd10;
	localparam logic [BRIGHT_W-1:0] RST_LEVEL_STEP = 16'd25;
	localparam logic [BRIGHT_W-1:0] RST_RAMP_TIME  = 16'd0;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [BRIGHT_W-1:0] measured_brightness;
	} req_t;

	typedef struct packed {
		logic [BRIGHT_W-1:0] drive_value;
		logic                drive_valid;
		logic [LEVEL_W-1:0]  current_level;
		logic                light_off;
		logic                ramp_active;
	} rsp_t;

endpackage

// ===== hw/rtl/blrc_mul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on blrc_pkg for the operand widths.
module blrc_mul import blrc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [BRIGHT_W-1:0] a,
	input  logic [BRIGHT_W-1:0] b,
	output logic                done,
	output logic [PROD_W-1:0]   product
);

	localparam int CNT_W = $clog2(BRIGHT_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BRIGHT_W - 1);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [BRIGHT_W-1:0] a_q;
	logic [BRIGHT_W-1:0] hi_q;
	logic [BRIGHT_W-1:0] lo_q;
	logic [BRIGHT_W:0]   sum;

	// add the multiplicand into the upper half when the next multiplier bit is set
	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : {(BRIGHT_W+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum[BRIGHT_W:1];
			lo_q <= {sum[0], lo_q[BRIGHT_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = {hi_q, lo_q};

endmodule

// ===== hw/rtl/blrc_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on blrc_pkg for the numerator and denominator widths.
module blrc_div import blrc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== hw/rtl/backlight_level_ramp_controller_core.sv =====
// Backlight level ramp controller core: top level with level state, command decode and tick sequencer.
// Depends on blrc_pkg, blrc_mul and blrc_div.
//
// Every accepted request yields exactly one response. Level commands (inc, dec, on, off,
// switch and the undefined codes) go from acceptance to the commit step, which hands over
// their response once the response register is free; the next request can be taken when
// the sequencer is back in idle. A tick first forms the target brightness with the
// bit-serial multiplier and then commits when the ramp time is at or below the direct limit
// or the measured value already equals the target. A ramping tick then uses the multiplier
// a second time for level_step * |difference| and the bit-serial divider for the rounded
// step before it commits. One request is in work at a time, but the next one is taken while
// a finished response still waits on a stalled output. Configuration writes take effect at
// once and are to be made only while idle.
module backlight_level_ramp_controller_core import blrc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req_data,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TGT  = 3'd1;  // wait for level_step * level
	localparam logic [2:0] ST_CMP  = 3'd2;  // choose direct, idle or ramp
	localparam logic [2:0] ST_MUL  = 3'd3;  // wait for level_step * |diff|
	localparam logic [2:0] ST_DIV  = 3'd4;  // wait for the rounded step
	localparam logic [2:0] ST_DONE = 3'd5;  // commit state, hand over response

	// configuration
	logic [BRIGHT_W-1:0] max_bright_q;
	logic [BRIGHT_W-1:0] min_bright_q;
	logic [LEVEL_W-1:0]  level_cnt_q;
	logic [BRIGHT_W-1:0] level_step_q;
	logic [BRIGHT_W-1:0] ramp_time_q;

	// controller state
	logic [LEVEL_W-1:0]  level_q;
	logic                off_q;
	logic [LEVEL_W-1:0]  saved_q;
	logic                saved_vld_q;

	// sequencer and request working registers
	logic [2:0]          state_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [BRIGHT_W-1:0] meas_q;
	logic [BRIGHT_W-1:0] tgt_q;
	logic [BRIGHT_W-1:0] dist_q;
	logic                neg_q;

	// tick outcome waiting for commit
	logic [BRIGHT_W-1:0] pend_drive_q;
	logic                pend_valid_q;
	logic                pend_active_q;
	logic                pend_save_q;

	// response register
	rsp_t                rsp_q;
	logic                rsp_vld_q;

	// serial units; the multiplier is shared by both tick products
	logic                mul_start;
	logic [BRIGHT_W-1:0] mul_b;
	logic                mul_done;
	logic [PROD_W-1:0]   mul_prod;
	logic                div_start;
	logic [NUM_W-1:0]    div_num;
	logic                div_done;
	logic [NUM_W-1:0]    div_quo;

	logic                req_take;
	logic                rsp_free;
	logic                direct;
	logic [BRIGHT_W-1:0] dist_nx;
	logic [PROD_W:0]     tgt_sum;
	logic [BRIGHT_W-1:0] tgt_nx;
	logic [PROD_W:0]     prod2;
	logic [NUM_W-1:0]    num_nx;
	logic [NUM_W-1:0]    step_mag;
	logic [BRIGHT_W-1:0] ramp_drive;
	logic [LEVEL_W-1:0]  load_level;
	logic [LEVEL_W-1:0]  level_nx;
	logic                off_nx;
	logic [LEVEL_W-1:0]  saved_nx;
	logic                saved_vld_nx;
	rsp_t                rsp_nx;

	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign rsp_free  = !rsp_vld_q || !rsp_stall;
	assign direct    = (ramp_time_q <= BRIGHT_W'(DIRECT_LIMIT));

	// distance between measured value and target
	assign dist_nx = (meas_q > tgt_q) ? (meas_q - tgt_q) : (tgt_q - meas_q);

	// start the multiplier for the target on a tick, and again for the ramp product
	assign mul_start = (req_take && (req_data.command == CMD_TICK)) ||
	                   ((state_q == ST_CMP) && !direct && (meas_q != tgt_q));
	assign mul_b     = (state_q == ST_CMP) ? dist_nx : {{(BRIGHT_W-LEVEL_W){1'b0}}, level_q};

	blrc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (level_step_q),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_prod)
	);

	// target: offset plus scaled level, clamped to the device maximum; zero while off
	assign tgt_sum = {1'b0, mul_prod} + {{(PROD_W+1-BRIGHT_W){1'b0}}, min_bright_q};
	assign tgt_nx  = off_q ? '0 :
	                 (tgt_sum > {{(PROD_W+1-BRIGHT_W){1'b0}}, max_bright_q}) ? max_bright_q :
	                 tgt_sum[BRIGHT_W-1:0];

	// numerator of the rounded step: 2*step*|diff| + ramp, or 2*step*|diff| - ramp
	// floored at zero when moving down (truncation toward zero)
	assign prod2 = {mul_prod, 1'b0};
	always_comb begin
		if (!neg_q) begin
			num_nx = {1'b0, prod2} + {{(NUM_W-BRIGHT_W){1'b0}}, ramp_time_q};
		end else if (prod2 >= {{(PROD_W+1-BRIGHT_W){1'b0}}, ramp_time_q}) begin
			num_nx = {1'b0, prod2 - {{(PROD_W+1-BRIGHT_W){1'b0}}, ramp_time_q}};
		end else begin
			num_nx = '0;
		end
	end

	assign div_start = (state_q == ST_MUL) && mul_done;
	assign div_num   = num_nx;

	blrc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    ({ramp_time_q, 1'b0}),
		.done   (div_done),
		.quo    (div_quo)
	);

	// move at least one unit, never past the target
	assign step_mag = (div_quo == '0) ? NUM_W'(1) : div_quo;
	always_comb begin
		if (step_mag >= {{(NUM_W-BRIGHT_W){1'b0}}, dist_q}) begin
			ramp_drive = tgt_q;
		end else if (neg_q) begin
			ramp_drive = meas_q - step_mag[BRIGHT_W-1:0];
		end else begin
			ramp_drive = meas_q + step_mag[BRIGHT_W-1:0];
		end
	end

	// restore the saved level if it is still in range, else take the middle level
	assign load_level = (saved_vld_q && (saved_q < level_cnt_q)) ? saved_q : (level_cnt_q >> 1);

	// state update and response for the request being committed
	always_comb begin
		level_nx            = level_q;
		off_nx              = off_q;
		saved_nx            = saved_q;
		saved_vld_nx        = saved_vld_q;
		rsp_nx.drive_value  = '0;
		rsp_nx.drive_valid  = 1'b0;
		rsp_nx.ramp_active  = 1'b1;
		unique case (cmd_q)
			CMD_TICK: begin
				rsp_nx.drive_value = pend_drive_q;
				rsp_nx.drive_valid = pend_valid_q;
				rsp_nx.ramp_active = pend_active_q;
				if (pend_save_q && !off_q) begin
					saved_nx     = level_q;
					saved_vld_nx = 1'b1;
				end
			end
			CMD_INC: begin
				if (off_q) begin
					level_nx = load_level;
					off_nx   = 1'b0;
				end else if (level_q < level_cnt_q) begin
					level_nx = level_q + 1'b1;
				end
			end
			CMD_DEC: begin
				if (off_q) begin
					level_nx = load_level;
					off_nx   = 1'b0;
				end else if (level_q != '0) begin
					level_nx = level_q - 1'b1;
				end
			end
			CMD_ON: begin
				level_nx = load_level;
				off_nx   = 1'b0;
			end
			CMD_OFF: begin
				if (!off_q) begin
					saved_nx     = level_q;
					saved_vld_nx = 1'b1;
				end
				off_nx = 1'b1;
			end
			CMD_SWITCH: begin
				if (off_q) begin
					level_nx = load_level;
					off_nx   = 1'b0;
				end else begin
					saved_nx     = level_q;
					saved_vld_nx = 1'b1;
					off_nx       = 1'b1;
				end
			end
			default: begin
				// undefined codes: drop the request, report idle
				rsp_nx.ramp_active = 1'b0;
			end
		endcase
		rsp_nx.current_level = level_nx;
		rsp_nx.light_off     = off_nx;
	end

	// configuration registers; writes beyond the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bright_q <= RST_MAX_BRIGHT;
			min_bright_q <= RST_MIN_BRIGHT;
			level_cnt_q  <= RST_LEVEL_CNT;
			level_step_q <= RST_LEVEL_STEP;
			ramp_time_q  <= RST_RAMP_TIME;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_BRIGHT: max_bright_q <= cfg_data[BRIGHT_W-1:0];
				REG_MIN_BRIGHT: min_bright_q <= cfg_data[BRIGHT_W-1:0];
				REG_LEVEL_CNT:  level_cnt_q  <= cfg_data[LEVEL_W-1:0];
				REG_LEVEL_STEP: level_step_q <= cfg_data[BRIGHT_W-1:0];
				REG_RAMP_TIME:  ramp_time_q  <= cfg_data[BRIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, controller state and response handover
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			level_q     <= '0;
			off_q       <= 1'b1;
			saved_q     <= '0;
			saved_vld_q <= 1'b0;
			rsp_vld_q   <= 1'b0;
		end else begin
			// release the response once the far side has taken it, unless a new one commits
			if (rsp_vld_q && !rsp_stall && (state_q != ST_DONE)) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						state_q <= (req_data.command == CMD_TICK) ? ST_TGT : ST_DONE;
					end
				end
				ST_TGT: begin
					if (mul_done) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= (direct || (meas_q == tgt_q)) ? ST_DONE : ST_MUL;
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the response register is free, then commit
					if (rsp_free) begin
						rsp_vld_q   <= 1'b1;
						level_q     <= level_nx;
						off_q       <= off_nx;
						saved_q     <= saved_nx;
						saved_vld_q <= saved_vld_nx;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request payload and tick working registers
	always_ff @(posedge clk) begin
		if (req_take) begin
			cmd_q  <= req_data.command;
			meas_q <= req_data.measured_brightness;
		end
		if ((state_q == ST_TGT) && mul_done) begin
			tgt_q <= tgt_nx;
		end
		if (state_q == ST_CMP) begin
			dist_q <= dist_nx;
			neg_q  <= (meas_q > tgt_q);
			if (direct) begin
				pend_drive_q  <= tgt_q;
				pend_valid_q  <= 1'b1;
				pend_active_q <= 1'b1;
				pend_save_q   <= 1'b0;
			end else if (meas_q == tgt_q) begin
				pend_drive_q  <= '0;
				pend_valid_q  <= 1'b0;
				pend_active_q <= 1'b0;
				pend_save_q   <= 1'b1;
			end
		end
		if ((state_q == ST_DIV) && div_done) begin
			pend_drive_q  <= ramp_drive;
			pend_valid_q  <= 1'b1;
			pend_active_q <= 1'b1;
			pend_save_q   <= 1'b0;
		end
		if ((state_q == ST_DONE) && rsp_free) begin
			rsp_q <= rsp_nx;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp_data  = rsp_q;

	// a fresh response only ever comes out of the commit step
	a_rsp_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_DONE))
		else $error("response raised outside the commit step");

	// a drive request always reports the ramp as active
	a_drive_active: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.drive_valid) |-> rsp_data.ramp_active)
		else $error("drive issued while ramp reported idle");

	// a non-zero drive value is never handed out without its valid flag
	a_drive_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp_data.drive_value != '0)) |-> rsp_data.drive_valid)
		else $error("drive value without drive flag");

	// the divider only runs after a ramp product has been formed
	a_div_order: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside its step");

endmodule
